// ===== rtl/mfs_pkg.sv =====
// shared types, codes and reset values of the motor fault supervisor
package mfs_pkg;

	// field widths
	localparam int CURRENT_W  = 16;
	localparam int VOLT_W     = 16;
	localparam int SPEED_W    = 16;
	localparam int HOLD_W     = 16;
	localparam int VHOLD_W    = 8;
	localparam int FAULT_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// derating: reference * 24576 >> 15, i.e. 75 percent
	localparam int DERATE_W     = 15;
	localparam int DERATE_SHIFT = 15;
	localparam logic [DERATE_W-1:0] DERATE_NUM = 15'd24576;

	// register reset values
	localparam logic signed [CURRENT_W-1:0] RST_OVERLOAD_LIMIT  = 16'sd32767;
	localparam logic [VOLT_W-1:0]           RST_OVERVOLT_LIMIT  = 16'd65535;
	localparam logic [VOLT_W-1:0]           RST_UNDERVOLT_LIMIT = 16'd0;
	localparam logic [SPEED_W-1:0]          RST_OVERSPEED_LIMIT = 16'd65535;
	localparam logic [HOLD_W-1:0]           RST_OVERLOAD_HOLD   = 16'd60000;
	localparam logic [VHOLD_W-1:0]          RST_VOLT_HOLD       = 8'd20;
	localparam logic [HOLD_W-1:0]           RST_OVERSPEED_HOLD  = 16'd3000;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OVERLOAD_LIMIT  = 3'd0,
		REG_OVERVOLT_LIMIT  = 3'd1,
		REG_UNDERVOLT_LIMIT = 3'd2,
		REG_OVERSPEED_LIMIT = 3'd3,
		REG_OVERLOAD_HOLD   = 3'd4,
		REG_VOLT_HOLD       = 3'd5,
		REG_OVERSPEED_HOLD  = 3'd6
	} cfg_idx_t;

	// latched fault codes
	typedef enum logic [FAULT_W-1:0] {
		FAULT_NONE      = 3'd0,
		FAULT_OVERLOAD  = 3'd1,
		FAULT_OVERVOLT  = 3'd2,
		FAULT_UNDERVOLT = 3'd3,
		FAULT_OVERSPEED = 3'd4
	} fault_code_t;

	typedef struct packed {
		logic signed [CURRENT_W-1:0] overload_limit;
		logic [VOLT_W-1:0]           overvolt_limit;
		logic [VOLT_W-1:0]           undervolt_limit;
		logic [SPEED_W-1:0]          overspeed_limit;
		logic [HOLD_W-1:0]           overload_hold;
		logic [VHOLD_W-1:0]          volt_hold;
		logic [HOLD_W-1:0]           overspeed_hold;
	} cfg_t;

	typedef struct packed {
		logic signed [CURRENT_W-1:0] torque_current;
		logic                        run_request;
		logic [VOLT_W-1:0]           bus_voltage;
		logic [SPEED_W-1:0]          motor_speed;
		logic                        derate_request;
		logic [SPEED_W-1:0]          speed_request;
	} sample_t;

	typedef struct packed {
		fault_code_t        fault_code;
		logic [SPEED_W-1:0] speed_reference;
		logic               run_enable;
	} status_t;

endpackage

// ===== rtl/mfs_if.sv =====
// valid/ready channel interfaces for input samples and status results
interface mfs_sample_if;
	import mfs_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [CURRENT_W-1:0] torque_current;
	logic                        run_request;
	logic [VOLT_W-1:0]           bus_voltage;
	logic [SPEED_W-1:0]          motor_speed;
	logic                        derate_request;
	logic [SPEED_W-1:0]          speed_request;

	modport source (
		output valid, torque_current, run_request, bus_voltage, motor_speed,
		       derate_request, speed_request,
		input  ready
	);
	modport sink (
		input  valid, torque_current, run_request, bus_voltage, motor_speed,
		       derate_request, speed_request,
		output ready
	);
endinterface

interface mfs_status_if;
	import mfs_pkg::*;

	logic               valid;
	logic               ready;
	logic [FAULT_W-1:0] fault_code;
	logic [SPEED_W-1:0] speed_reference;
	logic               run_enable;

	modport source (
		output valid, fault_code, speed_reference, run_enable,
		input  ready
	);
	modport sink (
		input  valid, fault_code, speed_reference, run_enable,
		output ready
	);
endinterface

// ===== rtl/mfs_cfg_regs.sv =====
// configuration register file: limits and hold times
module mfs_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfs_pkg::CFG_DATA_W-1:0] cfg_data,
	output mfs_pkg::cfg_t                  cfg
);
	import mfs_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.overload_limit  <= RST_OVERLOAD_LIMIT;
			cfg_q.overvolt_limit  <= RST_OVERVOLT_LIMIT;
			cfg_q.undervolt_limit <= RST_UNDERVOLT_LIMIT;
			cfg_q.overspeed_limit <= RST_OVERSPEED_LIMIT;
			cfg_q.overload_hold   <= RST_OVERLOAD_HOLD;
			cfg_q.volt_hold       <= RST_VOLT_HOLD;
			cfg_q.overspeed_hold  <= RST_OVERSPEED_HOLD;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_OVERLOAD_LIMIT:  cfg_q.overload_limit  <= $signed(cfg_data[CURRENT_W-1:0]);
				REG_OVERVOLT_LIMIT:  cfg_q.overvolt_limit  <= cfg_data[VOLT_W-1:0];
				REG_UNDERVOLT_LIMIT: cfg_q.undervolt_limit <= cfg_data[VOLT_W-1:0];
				REG_OVERSPEED_LIMIT: cfg_q.overspeed_limit <= cfg_data[SPEED_W-1:0];
				REG_OVERLOAD_HOLD:   cfg_q.overload_hold   <= cfg_data[HOLD_W-1:0];
				REG_VOLT_HOLD:       cfg_q.volt_hold       <= cfg_data[VHOLD_W-1:0];
				REG_OVERSPEED_HOLD:  cfg_q.overspeed_hold  <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/mfs_fault_core.sv =====
// fault counters, fault latch, derating and run enable for one sample
module mfs_fault_core (
	input  logic             clk,
	input  logic             arst_n,
	input  mfs_pkg::cfg_t    cfg,
	input  mfs_pkg::sample_t sample,
	input  logic             advance,
	output mfs_pkg::status_t status
);
	import mfs_pkg::*;

	logic [HOLD_W-1:0]  ol_count_q, ol_count_n;
	logic [VHOLD_W-1:0] ov_count_q, ov_count_n;
	logic [VHOLD_W-1:0] uv_count_q, uv_count_n;
	logic [HOLD_W-1:0]  os_count_q, os_count_n;
	fault_code_t        fault_q, fault_n;
	logic [SPEED_W+DERATE_W-1:0] derate_prod;

	// condition checks in order: overload, bus voltage, overspeed
	always_comb begin
		ol_count_n = ol_count_q;
		ov_count_n = ov_count_q;
		uv_count_n = uv_count_q;
		os_count_n = os_count_q;
		fault_n    = fault_q;

		if (sample.torque_current > cfg.overload_limit && sample.run_request) begin
			if (ol_count_q < cfg.overload_hold) ol_count_n = ol_count_q + 1'b1;
			else fault_n = FAULT_OVERLOAD;
		end else begin
			ol_count_n = '0;
		end

		if (sample.bus_voltage > cfg.overvolt_limit) begin
			if (ov_count_q < cfg.volt_hold) ov_count_n = ov_count_q + 1'b1;
			else fault_n = FAULT_OVERVOLT;
		end else if (sample.bus_voltage < cfg.undervolt_limit) begin
			if (uv_count_q < cfg.volt_hold) uv_count_n = uv_count_q + 1'b1;
			else fault_n = FAULT_UNDERVOLT;
		end else begin
			ov_count_n = '0;
			uv_count_n = '0;
		end

		// overspeed only fills an empty latch
		if (sample.motor_speed > cfg.overspeed_limit) begin
			if (os_count_q < cfg.overspeed_hold) os_count_n = os_count_q + 1'b1;
			else if (fault_n == FAULT_NONE) fault_n = FAULT_OVERSPEED;
		end else begin
			os_count_n = '0;
		end
	end

	// state update once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ol_count_q <= '0;
			ov_count_q <= '0;
			uv_count_q <= '0;
			os_count_q <= '0;
			fault_q    <= FAULT_NONE;
		end else if (advance) begin
			ol_count_q <= ol_count_n;
			ov_count_q <= ov_count_n;
			uv_count_q <= uv_count_n;
			os_count_q <= os_count_n;
			fault_q    <= fault_n;
		end
	end

	// speed reference derating and result fields
	assign derate_prod = sample.speed_request * DERATE_NUM;

	always_comb begin
		status.fault_code      = fault_n;
		status.speed_reference = sample.derate_request ?
			derate_prod[DERATE_SHIFT +: SPEED_W] : sample.speed_request;
		status.run_enable      = sample.run_request && (fault_n == FAULT_NONE);
	end

`ifndef NO_ASSERTIONS
	// a latched fault stays until reset
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q != FAULT_NONE |=> fault_q != FAULT_NONE)
		else $error("latched fault cleared");

	// overspeed never replaces another latched code
	a_overspeed_prio: assert property (@(posedge clk) disable iff (!arst_n)
		(fault_q == FAULT_OVERSPEED && $past(fault_q) != FAULT_OVERSPEED)
		|-> $past(fault_q) == FAULT_NONE)
		else $error("overspeed overwrote a latched fault");

	// counters and latch move only when a sample is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(ol_count_q) && $stable(ov_count_q) && $stable(uv_count_q)
			&& $stable(os_count_q) && $stable(fault_q)))
		else $error("supervisor state changed without a sample");
`endif

endmodule

// ===== rtl/motor_fault_supervisor.sv =====
// top level of the motor fault supervisor: input stage, fault core, result register
//
// channel  | dir | payload                                              | beat
// ---------+-----+------------------------------------------------------+-----------------
// sample   | in  | torque_current run_request bus_voltage motor_speed   | valid && ready
//          |     | derate_request speed_request                         |
// status   | out | fault_code speed_reference run_enable                | valid && ready
// cfg      | in  | cfg_index cfg_data                                   | cfg_we
//
// one sample per cycle sustained while status.ready stays high; a taken beat passes the input
// register, then counter/compare logic into the result register
// reset clears the counters, the fault latch and both valid flags, and loads the
// register reset values
// a stalled status beat holds; the input register still takes one more beat if it is empty, and
// the block keeps sample.ready high while it is empty or whenever the held sample can move on
module motor_fault_supervisor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfs_pkg::CFG_DATA_W-1:0] cfg_data,
	mfs_sample_if.sink                     sample,
	mfs_status_if.source                   status
);
	import mfs_pkg::*;

	cfg_t    cfg;
	sample_t sample_s1;
	logic    valid_s1;
	status_t result_n;
	status_t result_q;
	logic    out_valid_q;
	logic    advance;

	mfs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake: held sample moves on when the result register is free
	assign advance      = valid_s1 && (!out_valid_q || status.ready);
	assign sample.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sample_s1.torque_current <= sample.torque_current;
			sample_s1.run_request    <= sample.run_request;
			sample_s1.bus_voltage    <= sample.bus_voltage;
			sample_s1.motor_speed    <= sample.motor_speed;
			sample_s1.derate_request <= sample.derate_request;
			sample_s1.speed_request  <= sample.speed_request;
		end
	end

	mfs_fault_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.sample  (sample_s1),
		.advance (advance),
		.status  (result_n)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_n;
		end
	end

	assign status.valid           = out_valid_q;
	assign status.fault_code      = result_q.fault_code;
	assign status.speed_reference = result_q.speed_reference;
	assign status.run_enable      = result_q.run_enable;

endmodule

// ===== tb/motor_fault_supervisor_test.sv =====
// self-checking bench for the motor fault supervisor: directed tick table, then random ticks
module motor_fault_supervisor_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mfs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [31:0] DERATE_Q15 = 32'd24576;	// three quarters in Q15
	localparam int RANDOM_TICKS = 600;
	localparam int SEGMENTS = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 10;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;
	typedef enum int {BAND_INSIDE, BAND_OVER, BAND_UNDER, BAND_ANY} band_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
		sample_t               tick;
		bit                    typed;
		status_t               want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	mfs_sample_if sample ();
	mfs_status_if status ();

	motor_fault_supervisor DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.status    (status)
	);

	// predicted supervisor state and settings
	cfg_t               settings;
	fault_code_t        held_fault = FAULT_NONE;
	logic [HOLD_W-1:0]  overload_ticks = '0;
	logic [HOLD_W-1:0]  overspeed_ticks = '0;
	logic [VHOLD_W-1:0] overvolt_ticks = '0;
	logic [VHOLD_W-1:0] undervolt_ticks = '0;

	status_t   expected_status[$];
	plan_row_t plan[$];
	int        failures = 0;
	int        src_idle_pct = 0;
	int        sink_stall_pct = 0;
	int        quiet_cycles = 0;

	// regimes that keep random ticks near the trip points for a while
	bit    load_hot = 1'b0;
	bit    speed_hot = 1'b0;
	band_t volt_band = BAND_INSIDE;

	always #5 clk = ~clk;

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// register write as the block sees it
	function automatic void note_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		case (index)
			REG_OVERLOAD_LIMIT:  settings.overload_limit = data;
			REG_OVERVOLT_LIMIT:  settings.overvolt_limit = data;
			REG_UNDERVOLT_LIMIT: settings.undervolt_limit = data;
			REG_OVERSPEED_LIMIT: settings.overspeed_limit = data;
			REG_OVERLOAD_HOLD:   settings.overload_hold = data;
			REG_VOLT_HOLD:       settings.volt_hold = data[VHOLD_W-1:0];
			REG_OVERSPEED_HOLD:  settings.overspeed_hold = data;
			default: ;
		endcase
	endfunction

	// one supervision tick: counters, fault latch, derated reference
	function automatic status_t supervise(sample_t s);
		status_t     r;
		logic [31:0] scaled;
		// overload counts only while running, and overwrites any code
		if ($signed(s.torque_current) > $signed(settings.overload_limit) && s.run_request) begin
			if (overload_ticks < settings.overload_hold) overload_ticks++;
			else held_fault = FAULT_OVERLOAD;
		end else begin
			overload_ticks = '0;
		end
		// voltage: over first, both counters clear only inside the band
		if (s.bus_voltage > settings.overvolt_limit) begin
			if (overvolt_ticks < settings.volt_hold) overvolt_ticks++;
			else held_fault = FAULT_OVERVOLT;
		end else if (s.bus_voltage < settings.undervolt_limit) begin
			if (undervolt_ticks < settings.volt_hold) undervolt_ticks++;
			else held_fault = FAULT_UNDERVOLT;
		end else begin
			overvolt_ticks = '0;
			undervolt_ticks = '0;
		end
		// overspeed latches only onto a clean state
		if (s.motor_speed > settings.overspeed_limit) begin
			if (overspeed_ticks < settings.overspeed_hold) overspeed_ticks++;
			else if (held_fault == FAULT_NONE) held_fault = FAULT_OVERSPEED;
		end else begin
			overspeed_ticks = '0;
		end
		scaled = {16'b0, s.speed_request} * DERATE_Q15;
		r.speed_reference = s.derate_request ? scaled[30:15] : s.speed_request;
		r.fault_code = held_fault;
		r.run_enable = s.run_request && held_fault == FAULT_NONE;
		return r;
	endfunction

	function automatic plan_row_t tick_row(logic [15:0] cur, bit run, logic [15:0] vbus,
			logic [15:0] spd, bit der, logic [15:0] sreq);
		plan_row_t r;
		r.kind = ROW_TICK;
		r.index = '0;
		r.data = '0;
		r.tick.torque_current = cur;
		r.tick.run_request = run;
		r.tick.bus_voltage = vbus;
		r.tick.motor_speed = spd;
		r.tick.derate_request = der;
		r.tick.speed_request = sreq;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic plan_row_t write_row(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r = tick_row('0, 1'b0, '0, '0, 1'b0, '0);
		r.kind = ROW_WRITE;
		r.index = index;
		r.data = data;
		return r;
	endfunction

	function automatic plan_row_t expecting(plan_row_t r, fault_code_t code, logic [15:0] sref,
			bit en);
		r.typed = 1'b1;
		r.want.fault_code = code;
		r.want.speed_reference = sref;
		r.want.run_enable = en;
		return r;
	endfunction

	// random tick, hugging the current trip points while the hot regimes or a voltage band say so
	function automatic sample_t random_tick();
		sample_t s;
		if ($urandom_range(7) == 0) load_hot = !load_hot;
		if ($urandom_range(7) == 0) speed_hot = !speed_hot;
		if ($urandom_range(7) == 0) volt_band = band_t'($urandom_range(3));
		s.torque_current = load_hot ? settings.overload_limit + 16'($urandom_range(3))
			: 16'($urandom);
		s.run_request = $urandom_range(7) != 0;
		case (volt_band)
			BAND_OVER:   s.bus_voltage = settings.overvolt_limit + 16'($urandom_range(3));
			BAND_UNDER:  s.bus_voltage = settings.undervolt_limit - 16'($urandom_range(3));
			BAND_INSIDE: s.bus_voltage = 16'($urandom_range(settings.undervolt_limit,
				settings.overvolt_limit));
			default:     s.bus_voltage = 16'($urandom);
		endcase
		s.motor_speed = speed_hot ? settings.overspeed_limit + 16'($urandom_range(3))
			: 16'($urandom);
		s.derate_request = 1'($urandom_range(1));
		s.speed_request = 16'($urandom);
		return s;
	endfunction

	// settings per random segment, extremes first
	function automatic cfg_t pick_settings(int seg);
		cfg_t c;
		case (seg)
			0: begin
				// every condition trips at once
				c.overload_limit = 16'sh8000;
				c.overvolt_limit = 16'h0000;
				c.undervolt_limit = 16'hFFFF;
				c.overspeed_limit = 16'h0000;
				c.overload_hold = 16'h0000;
				c.volt_hold = 8'h00;
				c.overspeed_hold = 16'h0000;
			end
			1: begin
				// nothing can trip, longest holds
				c.overload_limit = 16'sh7FFF;
				c.overvolt_limit = 16'hFFFF;
				c.undervolt_limit = 16'h0000;
				c.overspeed_limit = 16'hFFFF;
				c.overload_hold = 16'hFFFF;
				c.volt_hold = 8'hFF;
				c.overspeed_hold = 16'hFFFF;
			end
			default: begin
				c.overload_limit = 16'($urandom);
				c.overvolt_limit = 16'($urandom_range(32768, 65535));
				c.undervolt_limit = 16'($urandom_range(0, 32767));
				c.overspeed_limit = 16'($urandom);
				c.overload_hold = 16'($urandom_range(6));
				c.volt_hold = 8'($urandom_range(6));
				c.overspeed_hold = 16'($urandom_range(6));
			end
		endcase
		return c;
	endfunction

	task automatic put_payload(sample_t s);
		sample.torque_current <= s.torque_current;
		sample.run_request <= s.run_request;
		sample.bus_voltage <= s.bus_voltage;
		sample.motor_speed <= s.motor_speed;
		sample.derate_request <= s.derate_request;
		sample.speed_request <= s.speed_request;
	endtask

	// one sample beat, with random gaps in front of it
	task automatic send_tick(sample_t s, bit typed, status_t want);
		status_t     predicted;
		sample_t     junk;
		logic [95:0] noise;
		while ($urandom_range(99) < src_idle_pct) begin
			noise = {$urandom, $urandom, $urandom};
			junk = noise[$bits(sample_t)-1:0];
			sample.valid <= 1'b0;
			put_payload(junk);
			@(posedge clk);
		end
		sample.valid <= 1'b1;
		put_payload(s);
		@(posedge clk);
		while (!sample.ready) @(posedge clk);
		predicted = supervise(s);
		expected_status.push_back(typed ? want : predicted);
	endtask

	task automatic wait_drained();
		while (expected_status.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		note_write(index, data);
	endtask

	task automatic apply_settings(cfg_t c);
		write_reg(REG_OVERLOAD_LIMIT, c.overload_limit);
		write_reg(REG_OVERVOLT_LIMIT, c.overvolt_limit);
		write_reg(REG_UNDERVOLT_LIMIT, c.undervolt_limit);
		write_reg(REG_OVERSPEED_LIMIT, c.overspeed_limit);
		write_reg(REG_OVERLOAD_HOLD, c.overload_hold);
		write_reg(REG_VOLT_HOLD, {8'b0, c.volt_hold});
		write_reg(REG_OVERSPEED_HOLD, c.overspeed_hold);
		cfg_we <= 1'b0;
	endtask

	// stimulus: directed table, then random segments
	initial begin
		plan_row_t row;
		bit        writing;
		settings.overload_limit = RST_OVERLOAD_LIMIT;
		settings.overvolt_limit = RST_OVERVOLT_LIMIT;
		settings.undervolt_limit = RST_UNDERVOLT_LIMIT;
		settings.overspeed_limit = RST_OVERSPEED_LIMIT;
		settings.overload_hold = RST_OVERLOAD_HOLD;
		settings.volt_hold = RST_VOLT_HOLD;
		settings.overspeed_hold = RST_OVERSPEED_HOLD;
		sample.valid = 1'b0;
		put_payload('0);

		// reset settings: no limit can be crossed, field extremes
		plan.push_back(expecting(tick_row(16'h0000, 0, 16'd0, 16'd0, 0, 16'd0),
			FAULT_NONE, 16'd0, 0));
		plan.push_back(expecting(tick_row(16'h7FFF, 1, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF),
			FAULT_NONE, 16'hFFFF, 1));
		plan.push_back(expecting(tick_row(16'h8000, 1, 16'd0, 16'd0, 1, 16'hFFFF),
			FAULT_NONE, 16'd49151, 1));
		plan.push_back(expecting(tick_row(16'hFFFF, 0, 16'h8000, 16'h8000, 1, 16'd4),
			FAULT_NONE, 16'd3, 0));
		plan.push_back(tick_row(16'h5555, 1, 16'hAAAA, 16'h5555, 1, 16'hAAAA));
		// overspeed counts up, clears at the limit, latches onto a clean state
		plan.push_back(write_row(REG_OVERSPEED_LIMIT, 16'd1000));
		plan.push_back(write_row(REG_OVERSPEED_HOLD, 16'd2));
		plan.push_back(expecting(tick_row(16'h0000, 1, 16'd100, 16'd1000, 0, 16'd500),
			FAULT_NONE, 16'd500, 1));
		plan.push_back(tick_row(16'h0000, 1, 16'd100, 16'd1001, 0, 16'd500));
		plan.push_back(tick_row(16'h0000, 1, 16'd100, 16'd1001, 0, 16'd500));
		plan.push_back(tick_row(16'h0000, 1, 16'd100, 16'd1000, 0, 16'd500));
		plan.push_back(tick_row(16'h0000, 1, 16'd100, 16'd1001, 0, 16'd500));
		plan.push_back(tick_row(16'h0000, 1, 16'd100, 16'd1001, 0, 16'd500));
		plan.push_back(expecting(tick_row(16'h0000, 1, 16'd100, 16'd1001, 0, 16'd500),
			FAULT_OVERSPEED, 16'd500, 0));
		// overload needs run, zero hold trips at once, overspeed cannot take over
		plan.push_back(write_row(REG_OVERLOAD_LIMIT, 16'd100));
		plan.push_back(write_row(REG_OVERLOAD_HOLD, 16'd0));
		plan.push_back(expecting(tick_row(16'd101, 0, 16'd100, 16'd1001, 0, 16'd0),
			FAULT_OVERSPEED, 16'd0, 0));
		plan.push_back(expecting(tick_row(16'd101, 1, 16'd100, 16'd1001, 0, 16'd0),
			FAULT_OVERLOAD, 16'd0, 0));
		plan.push_back(expecting(tick_row(16'h0000, 1, 16'd100, 16'd1001, 0, 16'd0),
			FAULT_OVERLOAD, 16'd0, 0));
		// voltage band: the idle counter holds outside the band, both clear inside
		plan.push_back(write_row(REG_OVERVOLT_LIMIT, 16'd50000));
		plan.push_back(write_row(REG_UNDERVOLT_LIMIT, 16'd10000));
		plan.push_back(write_row(REG_VOLT_HOLD, 16'd1));
		plan.push_back(expecting(tick_row(16'h0000, 1, 16'd50001, 16'd0, 0, 16'd0),
			FAULT_OVERLOAD, 16'd0, 0));
		plan.push_back(expecting(tick_row(16'h0000, 1, 16'd9999, 16'd0, 0, 16'd0),
			FAULT_OVERLOAD, 16'd0, 0));
		plan.push_back(expecting(tick_row(16'h0000, 1, 16'd50001, 16'd0, 0, 16'd0),
			FAULT_OVERVOLT, 16'd0, 0));
		plan.push_back(expecting(tick_row(16'h0000, 1, 16'd9999, 16'd0, 0, 16'd0),
			FAULT_UNDERVOLT, 16'd0, 0));
		plan.push_back(expecting(tick_row(16'h0000, 1, 16'd30000, 16'd0, 0, 16'd0),
			FAULT_UNDERVOLT, 16'd0, 0));
		plan.push_back(expecting(tick_row(16'h0000, 1, 16'd50001, 16'd0, 0, 16'd0),
			FAULT_UNDERVOLT, 16'd0, 0));
		// overload and overvoltage in one tick: voltage is checked later and wins
		plan.push_back(expecting(tick_row(16'd101, 1, 16'd50001, 16'd0, 0, 16'd0),
			FAULT_OVERVOLT, 16'd0, 0));
		plan.push_back(expecting(tick_row(16'd101, 1, 16'd10000, 16'd0, 0, 16'd0),
			FAULT_OVERLOAD, 16'd0, 0));
		// write to an unused index changes nothing
		plan.push_back(write_row(REG_UNUSED, 16'h0000));
		plan.push_back(tick_row(16'd50, 1, 16'd50001, 16'd0, 1, 16'd1234));

		wait (arst_n === 1'b1);
		@(posedge clk);
		src_idle_pct = 13;
		sink_stall_pct = 13;
		writing = 1'b0;
		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_WRITE) begin
				if (!writing) begin
					sample.valid <= 1'b0;
					wait_drained();
				end
				write_reg(row.index, row.data);
				writing = 1'b1;
			end else begin
				if (writing) cfg_we <= 1'b0;
				writing = 1'b0;
				send_tick(row.tick, row.typed, row.want);
			end
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			sample.valid <= 1'b0;
			wait_drained();
			apply_settings(pick_settings(seg));
			case (seg % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 51;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 51;
				end
				default: begin
					src_idle_pct = 13;
					sink_stall_pct = 13;
				end
			endcase
			load_hot = 1'($urandom_range(1));
			speed_hot = 1'($urandom_range(1));
			volt_band = band_t'($urandom_range(3));
			repeat (RANDOM_TICKS / SEGMENTS) send_tick(random_tick(), 1'b0, '0);
		end

		sample.valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && expected_status.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// status side: random stalls, each beat checked against the oldest expectation
	initial begin
		status_t want;
		status.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (status.valid && status.ready) begin
				if (expected_status.size() == 0) begin
					$error("status beat with no tick waiting for it");
					failures++;
				end else begin
					want = expected_status.pop_front();
					if (status.fault_code !== want.fault_code) begin
						$error("fault_code: expected %0d, got %0d", want.fault_code,
							status.fault_code);
						failures++;
					end
					if (status.speed_reference !== want.speed_reference) begin
						$error("speed_reference: expected %0d, got %0d",
							want.speed_reference, status.speed_reference);
						failures++;
					end
					if (status.run_enable !== want.run_enable) begin
						$error("run_enable: expected %0d, got %0d", want.run_enable,
							status.run_enable);
						failures++;
					end
				end
			end
			status.ready <= arst_n && ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (status.valid && status.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

// ===== files.f =====
rtl/mfs_pkg.sv
rtl/mfs_if.sv
rtl/mfs_cfg_regs.sv
rtl/mfs_fault_core.sv
rtl/motor_fault_supervisor.sv
tb/motor_fault_supervisor_test.sv
